### rtl/mcadc_pkg.sv
// Shared constants, codes and types for the multichannel ADC decimator.
// Used by the interfaces, the datapath modules, the top level and the checker.
`default_nettype none

package mcadc_pkg;

	// Scan geometry: channels per round, rounds per frame.
	localparam int CHANNELS   = 11;
	localparam int DECIMATION = 16;

	// Field widths.
	localparam int SAMPLE_W = 12;
	localparam int GAIN_W   = 18;
	localparam int CHAN_W   = 4;
	localparam int KIND_W   = 2;
	localparam int SCALED_W = 18;
	localparam int GAIN_Q   = 12;

	// Derived counter and accumulator widths.
	localparam int CH_CNT_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int RND_W     = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam int SUM_W     = $clog2(4095 * DECIMATION + 1);
	localparam int PROD_W    = SAMPLE_W + GAIN_W;
	localparam int SHIFTED_W = PROD_W - GAIN_Q;

	localparam logic [SCALED_W-1:0] SCALED_MAX = {SCALED_W{1'b1}};

	// Channel classes.
	localparam int VOLT_CHANNELS = 4;
	localparam int CURR_END      = 7;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 1'b1;

	localparam logic [GAIN_W-1:0] VOLTAGE_GAIN_RST = 18'd56925;
	localparam logic [GAIN_W-1:0] CURRENT_GAIN_RST = 18'd165000;

	typedef enum logic [KIND_W-1:0] {
		KIND_VOLTAGE = 2'd0,
		KIND_CURRENT = 2'd1,
		KIND_RAW     = 2'd2
	} kind_t;

	// Completed frame average on its way to the scaler.
	typedef struct packed {
		logic [CHAN_W-1:0]   channel;
		logic [SAMPLE_W-1:0] average;
		kind_t               kind;
		logic                frame_last;
	} stage_t;

endpackage

`default_nettype wire

### rtl/mcadc_sample_if.sv
// Sample stream channel: valid/ready handshake with one raw ADC word.
// Depends on mcadc_pkg for the sample width.
`default_nettype none

interface mcadc_sample_if;
	logic                          valid;
	logic                          ready;
	logic [mcadc_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

### rtl/mcadc_result_if.sv
// Result stream channel: valid/ready handshake with one frame average word.
// Depends on mcadc_pkg for the field widths.
`default_nettype none

interface mcadc_result_if;
	logic                          valid;
	logic                          ready;
	logic [mcadc_pkg::CHAN_W-1:0]   channel;
	logic [mcadc_pkg::SAMPLE_W-1:0] average;
	logic [mcadc_pkg::KIND_W-1:0]   kind;
	logic [mcadc_pkg::SCALED_W-1:0] scaled;
	logic                          frame_last;

	modport source (output valid, output channel, output average, output kind,
		output scaled, output frame_last, input ready);
	modport sink   (input valid, input channel, input average, input kind,
		input scaled, input frame_last, output ready);
endinterface

`default_nettype wire

### rtl/mcadc_accum.sv
// Per-channel accumulators, scan counters and the first pipeline register.
// Depends on mcadc_pkg.
`default_nettype none

module mcadc_accum (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [mcadc_pkg::SAMPLE_W-1:0] sample,
	output logic                                in_ready,
	input  wire logic                           take,
	output logic                                stage_valid,
	output mcadc_pkg::stage_t                   stage
);
	logic [mcadc_pkg::SUM_W-1:0]    sums_q [mcadc_pkg::CHANNELS];
	logic [mcadc_pkg::CH_CNT_W-1:0] ch_q;
	logic [mcadc_pkg::RND_W-1:0]    round_q;
	logic                           valid_s1;
	mcadc_pkg::stage_t              data_s1;

	logic                           accept;
	logic                           final_round;
	logic                           last_ch;
	logic [mcadc_pkg::SUM_W-1:0]    sum_new;
	mcadc_pkg::kind_t               kind;

	assign in_ready    = !valid_s1 || take;
	assign accept      = in_valid && in_ready;
	assign final_round = (round_q == mcadc_pkg::RND_W'(mcadc_pkg::DECIMATION - 1));
	assign last_ch     = (ch_q == mcadc_pkg::CH_CNT_W'(mcadc_pkg::CHANNELS - 1));
	assign sum_new     = sums_q[ch_q] + mcadc_pkg::SUM_W'(sample);

	always_comb begin
		if (ch_q < mcadc_pkg::CH_CNT_W'(mcadc_pkg::VOLT_CHANNELS)) begin
			kind = mcadc_pkg::KIND_VOLTAGE;
		end else if (ch_q < mcadc_pkg::CH_CNT_W'(mcadc_pkg::CURR_END)) begin
			kind = mcadc_pkg::KIND_CURRENT;
		end else begin
			kind = mcadc_pkg::KIND_RAW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mcadc_pkg::CHANNELS; i++) begin
				sums_q[i] <= '0;
			end
			ch_q     <= '0;
			round_q  <= '0;
			valid_s1 <= 1'b0;
		end else if (accept) begin
			// Clear the sum once its frame completes.
			sums_q[ch_q] <= final_round ? '0 : sum_new;
			valid_s1     <= final_round;
			if (last_ch) begin
				ch_q    <= '0;
				round_q <= final_round ? '0 : round_q + 1'b1;
			end else begin
				ch_q <= ch_q + 1'b1;
			end
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && final_round) begin
			data_s1.channel    <= mcadc_pkg::CHAN_W'(ch_q);
			data_s1.average    <= mcadc_pkg::SAMPLE_W'(sum_new / mcadc_pkg::DECIMATION);
			data_s1.kind       <= kind;
			data_s1.frame_last <= last_ch;
		end
	end

	assign stage_valid = valid_s1;
	assign stage       = data_s1;
endmodule

`default_nettype wire

### rtl/mcadc_scale.sv
// Gain multiply, Q12 shift, clamp and the result register.
// Depends on mcadc_pkg.
`default_nettype none

module mcadc_scale (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           stage_valid,
	input  wire mcadc_pkg::stage_t              stage,
	output logic                                take,
	input  wire logic [mcadc_pkg::GAIN_W-1:0]   voltage_gain,
	input  wire logic [mcadc_pkg::GAIN_W-1:0]   current_gain,
	input  wire logic                           out_ready,
	output logic                                out_valid,
	output mcadc_pkg::stage_t                   out_data,
	output logic [mcadc_pkg::SCALED_W-1:0]      scaled
);
	logic                            valid_q;
	mcadc_pkg::stage_t               data_q;
	logic [mcadc_pkg::SCALED_W-1:0]  scaled_q;

	logic [mcadc_pkg::GAIN_W-1:0]    gain;
	logic [mcadc_pkg::PROD_W-1:0]    prod;
	logic [mcadc_pkg::SHIFTED_W-1:0] shifted;
	logic [mcadc_pkg::SCALED_W-1:0]  scaled_d;

	assign take = !valid_q || out_ready;

	always_comb begin
		gain = (stage.kind == mcadc_pkg::KIND_VOLTAGE) ? voltage_gain : current_gain;
		prod    = mcadc_pkg::PROD_W'(stage.average) * mcadc_pkg::PROD_W'(gain);
		shifted = prod[mcadc_pkg::PROD_W-1:mcadc_pkg::GAIN_Q];
		if (stage.kind == mcadc_pkg::KIND_RAW) begin
			scaled_d = mcadc_pkg::SCALED_W'(stage.average);
		end else if (shifted > mcadc_pkg::SHIFTED_W'(mcadc_pkg::SCALED_MAX)) begin
			scaled_d = mcadc_pkg::SCALED_MAX;
		end else begin
			scaled_d = shifted[mcadc_pkg::SCALED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= stage_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && stage_valid) begin
			data_q   <= stage;
			scaled_q <= scaled_d;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign scaled    = scaled_q;
endmodule

`default_nettype wire

### rtl/multichannel_adc_decimate_convert_top.sv
// A final-round result word passes the stage register, then the output register.
// Throughput: one sample word per cycle unless stalled; non-final rounds yield no word.
// Rate is set by the single accumulate add per sample and one gain multiply per result.
// Reset (arst_n low, asynchronous) clears sums, scan counters and valid flags,
// and loads the gain registers with their default values.
// Depends on mcadc_pkg, mcadc_sample_if, mcadc_result_if, mcadc_accum, mcadc_scale.
`default_nettype none

module multichannel_adc_decimate_convert_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	mcadc_sample_if.sink                         samples,
	mcadc_result_if.source                       results,
	input  wire logic                            wr_en,
	input  wire logic [mcadc_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [mcadc_pkg::GAIN_W-1:0]    wr_data
);
	// Gain registers; the user must write them only with the pipeline empty (unenforced).
	logic [mcadc_pkg::GAIN_W-1:0] voltage_gain_q;
	logic [mcadc_pkg::GAIN_W-1:0] current_gain_q;

	logic              stage_valid;
	mcadc_pkg::stage_t stage;
	logic              take;
	mcadc_pkg::stage_t out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_gain_q <= mcadc_pkg::VOLTAGE_GAIN_RST;
			current_gain_q <= mcadc_pkg::CURRENT_GAIN_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				mcadc_pkg::REG_VOLTAGE_GAIN: voltage_gain_q <= wr_data;
				mcadc_pkg::REG_CURRENT_GAIN: current_gain_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Stage 1: accumulate the sample into its channel's sum; on the final
	// round, capture the truncated average and the channel class.
	mcadc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (samples.valid),
		.sample      (samples.sample),
		.in_ready    (samples.ready),
		.take        (take),
		.stage_valid (stage_valid),
		.stage       (stage)
	);

	// Stage 2: apply the class gain and hold the word in the output register.
	// Stage 1 advances whenever the output register is empty or being drained.
	mcadc_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage_valid  (stage_valid),
		.stage        (stage),
		.take         (take),
		.voltage_gain (voltage_gain_q),
		.current_gain (current_gain_q),
		.out_ready    (results.ready),
		.out_valid    (results.valid),
		.out_data     (out_data),
		.scaled       (results.scaled)
	);

	assign results.channel    = out_data.channel;
	assign results.average    = out_data.average;
	assign results.kind       = out_data.kind;
	assign results.frame_last = out_data.frame_last;
endmodule

`default_nettype wire

### rtl/mcadc_checker.sv
// Port-level checks on the result stream of the decimator, bound to the top level.
// Depends on mcadc_pkg and multichannel_adc_decimate_convert_top.
`default_nettype none

module mcadc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [mcadc_pkg::CHAN_W-1:0]   channel,
	input wire logic [mcadc_pkg::SAMPLE_W-1:0] average,
	input wire logic [mcadc_pkg::KIND_W-1:0]   kind,
	input wire logic [mcadc_pkg::SCALED_W-1:0] scaled,
	input wire logic                           frame_last
);
	// Hold a stalled word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({channel, average, kind, scaled, frame_last}))
		else $error("result word changed while stalled");

	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel < mcadc_pkg::CHAN_W'(mcadc_pkg::CHANNELS))
		else $error("channel out of range");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_last == (channel == mcadc_pkg::CHAN_W'(mcadc_pkg::CHANNELS - 1)))
		else $error("frame_last does not match channel");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (channel < mcadc_pkg::CHAN_W'(mcadc_pkg::VOLT_CHANNELS)
				&& kind == mcadc_pkg::KIND_VOLTAGE)
			|| (channel >= mcadc_pkg::CHAN_W'(mcadc_pkg::VOLT_CHANNELS)
				&& channel < mcadc_pkg::CHAN_W'(mcadc_pkg::CURR_END)
				&& kind == mcadc_pkg::KIND_CURRENT)
			|| (channel >= mcadc_pkg::CHAN_W'(mcadc_pkg::CURR_END)
				&& kind == mcadc_pkg::KIND_RAW))
		else $error("kind does not match channel class");

	a_raw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == mcadc_pkg::KIND_RAW
			|-> scaled == mcadc_pkg::SCALED_W'(average))
		else $error("raw channel scaled value differs from average");
endmodule

bind multichannel_adc_decimate_convert_top mcadc_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.channel    (results.channel),
	.average    (results.average),
	.kind       (results.kind),
	.scaled     (results.scaled),
	.frame_last (results.frame_last)
);

`default_nettype wire

### tb/multichannel_adc_decimate_convert_top_test.sv
// Self-checking testbench for the multichannel ADC decimator and unit converter.
// Depends on mcadc_pkg, mcadc_sample_if, mcadc_result_if and the top level it drives.
`timescale 1ns / 100ps

module multichannel_adc_decimate_convert_top_test;

	// Cycles to let pass once no word is expected: a non-final sample may still be
	// in flight, and a final-round word still passes the stage and output registers.
	localparam int DRAIN_CYCLES = 6;
	// Time-out bound, set far above the length of the slowest run.
	localparam int CYCLE_LIMIT  = 200000;
	localparam int FRAME_WORDS  = mcadc_pkg::CHANNELS * mcadc_pkg::DECIMATION;

	// How one frame of directed samples is formed.
	typedef enum {
		PAT_CONST,   // every sample equals the base
		PAT_RAMP,    // base plus the round index, so the sum is not a multiple
		PAT_RANDOM   // uniform random samples
	} frame_pattern_t;

	// One row of the directed table: gains, one frame of samples and, where typed,
	// the average and the scaled values every channel class must report.
	typedef struct {
		logic [mcadc_pkg::GAIN_W-1:0]   vgain;
		logic [mcadc_pkg::GAIN_W-1:0]   igain;
		frame_pattern_t                 pattern;
		logic [mcadc_pkg::SAMPLE_W-1:0] base;
		logic                           typed;
		logic [mcadc_pkg::SAMPLE_W-1:0] avg;
		logic [mcadc_pkg::SCALED_W-1:0] v_scaled;
		logic [mcadc_pkg::SCALED_W-1:0] i_scaled;
	} frame_row_t;

	// One frame average word as it leaves the block.
	typedef struct {
		logic [mcadc_pkg::CHAN_W-1:0]   channel;
		logic [mcadc_pkg::SAMPLE_W-1:0] average;
		mcadc_pkg::kind_t               kind;
		logic [mcadc_pkg::SCALED_W-1:0] scaled;
		logic                           frame_last;
	} avg_word_t;

	logic                            clk;
	logic                            arst_n;
	logic                            wr_en;
	logic [mcadc_pkg::CFG_IDX_W-1:0] wr_index;
	logic [mcadc_pkg::GAIN_W-1:0]    wr_data;

	mcadc_sample_if adc_in ();
	mcadc_result_if avg_out ();

	multichannel_adc_decimate_convert_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (adc_in),
		.results  (avg_out),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Predicted state of the block: gains, per-channel sums and scan position.
	logic [mcadc_pkg::GAIN_W-1:0] volt_gain;
	logic [mcadc_pkg::GAIN_W-1:0] curr_gain;
	int unsigned                  channel_sum [mcadc_pkg::CHANNELS];
	int                           scan_channel;
	int                           scan_round;

	// Averages predicted and not yet seen on the result channel, oldest first.
	avg_word_t pending_averages [$];
	avg_word_t seen_want;

	// Directed row in effect and whether its typed values replace the prediction.
	frame_row_t typed_row;
	logic       typed_frame;
	frame_row_t frame_plan [2];

	int send_idle_pct = 20;
	int recv_idle_pct = 20;
	int stall_request = 0;
	int mismatch_count = 0;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Time-out: end the run if the stimulus and the drain never finish.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timed out with %0d words outstanding", $time, pending_averages.size());
		$display("*** FAILED ***");
		$finish;
	end

	// (average * gain) >> 12, clamped to the widest scaled value.
	function automatic logic [mcadc_pkg::SCALED_W-1:0] gain_scale(
		logic [mcadc_pkg::SAMPLE_W-1:0] avg, logic [mcadc_pkg::GAIN_W-1:0] gain);
		longint unsigned prod;
		prod = (64'(avg) * 64'(gain)) >> mcadc_pkg::GAIN_Q;
		if (prod > 64'(mcadc_pkg::SCALED_MAX))
			prod = 64'(mcadc_pkg::SCALED_MAX);
		return prod[mcadc_pkg::SCALED_W-1:0];
	endfunction

	// Fold one accepted sample into the sums; on the final round, queue the
	// channel's frame average and clear its sum.
	task automatic absorb_sample(input logic [mcadc_pkg::SAMPLE_W-1:0] value);
		avg_word_t w;
		channel_sum[scan_channel] += value;
		if (scan_round == mcadc_pkg::DECIMATION - 1) begin
			w.channel    = mcadc_pkg::CHAN_W'(scan_channel);
			w.average    = mcadc_pkg::SAMPLE_W'(channel_sum[scan_channel]
				/ mcadc_pkg::DECIMATION);
			w.frame_last = (scan_channel == mcadc_pkg::CHANNELS - 1);
			if (scan_channel < mcadc_pkg::VOLT_CHANNELS) begin
				w.kind   = mcadc_pkg::KIND_VOLTAGE;
				w.scaled = gain_scale(w.average, volt_gain);
			end else if (scan_channel < mcadc_pkg::CURR_END) begin
				w.kind   = mcadc_pkg::KIND_CURRENT;
				w.scaled = gain_scale(w.average, curr_gain);
			end else begin
				w.kind   = mcadc_pkg::KIND_RAW;
				w.scaled = mcadc_pkg::SCALED_W'(w.average);
			end
			// Directed extremes: take the hand-worked values instead.
			if (typed_frame) begin
				w.average = typed_row.avg;
				case (w.kind)
					mcadc_pkg::KIND_VOLTAGE: w.scaled = typed_row.v_scaled;
					mcadc_pkg::KIND_CURRENT: w.scaled = typed_row.i_scaled;
					default: w.scaled = mcadc_pkg::SCALED_W'(typed_row.avg);
				endcase
			end
			channel_sum[scan_channel] = 0;
			pending_averages.push_back(w);
		end
		scan_channel++;
		if (scan_channel == mcadc_pkg::CHANNELS) begin
			scan_channel = 0;
			scan_round   = (scan_round + 1) % mcadc_pkg::DECIMATION;
		end
	endtask

	// Offer one sample word, idling first at random, and hold it until accepted.
	// Valid stays high on return so back-to-back words need no extra step.
	task automatic send_word(input logic [mcadc_pkg::SAMPLE_W-1:0] value);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			adc_in.valid <= 1'b0;
			@(posedge clk);
		end
		adc_in.valid  <= 1'b1;
		adc_in.sample <= value;
		@(posedge clk);
		while (!adc_in.ready)
			@(posedge clk);
		absorb_sample(value);
	endtask

	// Drop valid and wait until every predicted word has come out, then let the
	// pipeline settle so a register write cannot land on a word in flight.
	task automatic drain_averages();
		adc_in.valid <= 1'b0;
		@(posedge clk);
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the voltage gain, then the current gain register; call only while idle.
	task automatic set_gains(input logic [mcadc_pkg::GAIN_W-1:0] vgain,
		input logic [mcadc_pkg::GAIN_W-1:0] igain);
		wr_en    <= 1'b1;
		wr_index <= mcadc_pkg::REG_VOLTAGE_GAIN;
		wr_data  <= vgain;
		@(posedge clk);
		wr_index <= mcadc_pkg::REG_CURRENT_GAIN;
		wr_data  <= igain;
		@(posedge clk);
		wr_en    <= 1'b0;
		volt_gain = vgain;
		curr_gain = igain;
	endtask

	function automatic logic [mcadc_pkg::GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return mcadc_pkg::GAIN_W'($urandom);
		endcase
	endfunction

	// Mostly uniform samples, with the rails mixed in now and then.
	function automatic logic [mcadc_pkg::SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			default: return mcadc_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [mcadc_pkg::SAMPLE_W-1:0] row_sample(frame_row_t row, int rnd);
		case (row.pattern)
			PAT_CONST: return row.base;
			PAT_RAMP:  return row.base + mcadc_pkg::SAMPLE_W'(rnd);
			default:   return mcadc_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	// One random phase: new gains while idle, then a run of random samples.
	task automatic run_phase(input int send_pct, input int recv_pct, input int words,
		input int stall);
		drain_averages();
		set_gains(pick_gain(), pick_gain());
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		stall_request = stall;
		repeat (words) send_word(pick_sample());
	endtask

	// Receiver: take result words with random idling; on request, hold ready low
	// for a long stretch so the block backs up and stalls its sample input.
	initial begin
		avg_out.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				avg_out.ready <= 1'b0;
				repeat (stall_request) @(posedge clk);
				stall_request = 0;
			end
			avg_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Checker: compare every accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && avg_out.valid === 1'b1 && avg_out.ready === 1'b1) begin
			if (pending_averages.size() == 0) begin
				$display("%0t: unexpected word, expected none, actual channel %0d average %0d",
					$time, avg_out.channel, avg_out.average);
				mismatch_count++;
			end else begin
				seen_want = pending_averages.pop_front();
				compare_field("channel", 32'(seen_want.channel), 32'(avg_out.channel));
				compare_field("average", 32'(seen_want.average), 32'(avg_out.average));
				compare_field("kind", 32'(seen_want.kind), 32'(avg_out.kind));
				compare_field("scaled", 32'(seen_want.scaled), 32'(avg_out.scaled));
				compare_field("frame_last", 32'(seen_want.frame_last),
					32'(avg_out.frame_last));
			end
		end
	end

	initial begin
		// Hold every input at a known value and assert reset.
		arst_n        <= 1'b0;
		wr_en         <= 1'b0;
		wr_index      <= mcadc_pkg::REG_VOLTAGE_GAIN;
		wr_data       <= '0;
		adc_in.valid  <= 1'b0;
		adc_in.sample <= '0;
		volt_gain     = mcadc_pkg::VOLTAGE_GAIN_RST;
		curr_gain     = mcadc_pkg::CURRENT_GAIN_RST;
		foreach (channel_sum[c])
			channel_sum[c] = 0;
		scan_channel  = 0;
		scan_round    = 0;
		typed_frame   = 1'b0;

		// Directed frames. Typed rows: all-zero frame at the reset gains;
		// full-scale average against the widest gain (largest product).
		frame_plan = '{
			'{mcadc_pkg::VOLTAGE_GAIN_RST, mcadc_pkg::CURRENT_GAIN_RST, PAT_CONST,
				12'd0, 1'b1, 12'd0, 18'd0, 18'd0},
			'{18'd262143, 18'd262143, PAT_CONST,
				12'd4095, 1'b1, 12'd4095, 18'd262079, 18'd262079}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table one whole frame per row; the first row runs on the
		// reset gains, so write the registers only where a row changes them.
		foreach (frame_plan[r]) begin
			drain_averages();
			if (frame_plan[r].vgain != volt_gain || frame_plan[r].igain != curr_gain)
				set_gains(frame_plan[r].vgain, frame_plan[r].igain);
			typed_row   = frame_plan[r];
			typed_frame = frame_plan[r].typed;
			for (int rnd = 0; rnd < mcadc_pkg::DECIMATION; rnd++)
				for (int c = 0; c < mcadc_pkg::CHANNELS; c++)
					send_word(row_sample(frame_plan[r], rnd));
		end
		drain_averages();
		typed_frame = 1'b0;

		// Random part: a slow receiver, then a slow sender, then full rate with one
		// long receiver hold-off while samples keep coming. Each phase spans the
		// final round of one frame, so every phase sees result words.
		run_phase(6, 85, 200, 0);
		run_phase(85, 6, 200, 0);
		run_phase(0, 0, 200, 4 * FRAME_WORDS / 2);

		drain_averages();
		if (mismatch_count == 0 && pending_averages.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
